### hdl/cocd_pkg.sv
// Types, kind codes and the opcode pattern table for the opcode class decoder.
// No dependencies; used by cpu_opcode_class_decoder and tb_cpu_opcode_class_decoder.
`default_nettype none
package cocd_pkg;

  typedef enum logic [1:0] {
    TBL_BASE = 2'd0,
    TBL_CB   = 2'd1,
    TBL_IDX  = 2'd2
  } tbl_t;

  typedef enum logic [5:0] {
    KIND_BIT  = 6'd0,  KIND_RES  = 6'd1,  KIND_SET  = 6'd2,  KIND_RLC  = 6'd3,
    KIND_RL   = 6'd4,  KIND_RRC  = 6'd5,  KIND_RR   = 6'd6,  KIND_SLA  = 6'd7,
    KIND_SRA  = 6'd8,  KIND_SRL  = 6'd9,  KIND_SWAP = 6'd10, KIND_LD   = 6'd11,
    KIND_RLCA = 6'd12, KIND_RLA  = 6'd13, KIND_JR   = 6'd14, KIND_JP   = 6'd15,
    KIND_RRCA = 6'd16, KIND_RRA  = 6'd17, KIND_ADD  = 6'd18, KIND_RET  = 6'd19,
    KIND_CALL = 6'd20, KIND_ADC  = 6'd21, KIND_SUB  = 6'd22, KIND_SBC  = 6'd23,
    KIND_AND  = 6'd24, KIND_OR   = 6'd25, KIND_XOR  = 6'd26, KIND_LDHL = 6'd27,
    KIND_CP   = 6'd28, KIND_INC  = 6'd29, KIND_DEC  = 6'd30, KIND_PUSH = 6'd31,
    KIND_POP  = 6'd32
  } kind_t;

  localparam logic [7:0] PREFIX_CB = 8'hCB;
  localparam logic [7:0] PREFIX_DD = 8'hDD;
  localparam logic [7:0] PREFIX_FD = 8'hFD;

  typedef struct packed {
    tbl_t       tbl;
    logic [7:0] mask;
    logic [7:0] value;
    kind_t      kind;
  } rule_t;

  typedef struct packed {
    logic  found;
    kind_t kind;
  } grp_t;

  localparam int NumRules  = 74;
  localparam int GroupSize = 8;
  localparam int NumGroups = (NumRules + GroupSize - 1) / GroupSize;

  // Priority order: lower index wins.
  localparam rule_t Rules [NumRules] = '{
    // CB table
    '{TBL_CB, 8'hC0, 8'h40, KIND_BIT},  '{TBL_CB, 8'hC0, 8'h80, KIND_RES},
    '{TBL_CB, 8'hC0, 8'hC0, KIND_SET},  '{TBL_CB, 8'hF8, 8'h00, KIND_RLC},
    '{TBL_CB, 8'hF8, 8'h10, KIND_RL},   '{TBL_CB, 8'hF8, 8'h08, KIND_RRC},
    '{TBL_CB, 8'hF8, 8'h18, KIND_RR},   '{TBL_CB, 8'hF8, 8'h20, KIND_SLA},
    '{TBL_CB, 8'hF8, 8'h28, KIND_SRA},  '{TBL_CB, 8'hF8, 8'h38, KIND_SRL},
    '{TBL_CB, 8'hF8, 8'h30, KIND_SWAP},
    // DD / FD table
    '{TBL_IDX, 8'hC7, 8'h46, KIND_LD},  '{TBL_IDX, 8'hF8, 8'h70, KIND_LD},
    // base table
    '{TBL_BASE, 8'hFF, 8'h07, KIND_RLCA},
    '{TBL_BASE, 8'hFF, 8'h17, KIND_RLA},
    '{TBL_BASE, 8'hFF, 8'h18, KIND_JR},   '{TBL_BASE, 8'hE7, 8'h20, KIND_JR},
    '{TBL_BASE, 8'hFF, 8'hE9, KIND_JP},   '{TBL_BASE, 8'hE6, 8'hC2, KIND_JP},
    '{TBL_BASE, 8'hFF, 8'h0F, KIND_RRCA},
    '{TBL_BASE, 8'hFF, 8'h1F, KIND_RRA},
    '{TBL_BASE, 8'hCF, 8'h09, KIND_ADD},  '{TBL_BASE, 8'hFF, 8'h86, KIND_ADD},
    '{TBL_BASE, 8'hF8, 8'h80, KIND_ADD},  '{TBL_BASE, 8'hFF, 8'hC6, KIND_ADD},
    '{TBL_BASE, 8'hFF, 8'hE8, KIND_ADD},
    '{TBL_BASE, 8'hE7, 8'hC0, KIND_RET},  '{TBL_BASE, 8'hFF, 8'hC9, KIND_RET},
    '{TBL_BASE, 8'hFF, 8'hCD, KIND_CALL}, '{TBL_BASE, 8'hE7, 8'hC4, KIND_CALL},
    '{TBL_BASE, 8'hFF, 8'hCE, KIND_ADC},  '{TBL_BASE, 8'hFF, 8'h8E, KIND_ADC},
    '{TBL_BASE, 8'hF8, 8'h88, KIND_ADC},
    '{TBL_BASE, 8'hF8, 8'h90, KIND_SUB},  '{TBL_BASE, 8'hFF, 8'hD6, KIND_SUB},
    '{TBL_BASE, 8'hFF, 8'hDE, KIND_SBC},  '{TBL_BASE, 8'hFF, 8'h9E, KIND_SBC},
    '{TBL_BASE, 8'hF8, 8'h98, KIND_SBC},
    '{TBL_BASE, 8'hFF, 8'hE6, KIND_AND},  '{TBL_BASE, 8'hFF, 8'hA6, KIND_AND},
    '{TBL_BASE, 8'hF8, 8'hA0, KIND_AND},
    '{TBL_BASE, 8'hFF, 8'hF6, KIND_OR},   '{TBL_BASE, 8'hFF, 8'hB6, KIND_OR},
    '{TBL_BASE, 8'hF8, 8'hB0, KIND_OR},
    '{TBL_BASE, 8'hFF, 8'hEE, KIND_XOR},  '{TBL_BASE, 8'hFF, 8'hAE, KIND_XOR},
    '{TBL_BASE, 8'hF8, 8'hA8, KIND_XOR},
    '{TBL_BASE, 8'hFF, 8'hF8, KIND_LDHL},
    '{TBL_BASE, 8'hFF, 8'hFE, KIND_CP},   '{TBL_BASE, 8'hFF, 8'hBE, KIND_CP},
    '{TBL_BASE, 8'hF8, 8'hB8, KIND_CP},
    '{TBL_BASE, 8'hFF, 8'h34, KIND_INC},  '{TBL_BASE, 8'hC7, 8'h04, KIND_INC},
    '{TBL_BASE, 8'hCF, 8'h03, KIND_INC},
    '{TBL_BASE, 8'hFF, 8'h35, KIND_DEC},  '{TBL_BASE, 8'hC7, 8'h05, KIND_DEC},
    '{TBL_BASE, 8'hCF, 8'h0B, KIND_DEC},
    '{TBL_BASE, 8'hCF, 8'hC5, KIND_PUSH},
    '{TBL_BASE, 8'hCF, 8'hC1, KIND_POP},
    '{TBL_BASE, 8'hFF, 8'h08, KIND_LD},   '{TBL_BASE, 8'hCF, 8'h01, KIND_LD},
    '{TBL_BASE, 8'hFF, 8'h36, KIND_LD},   '{TBL_BASE, 8'hEF, 8'h2A, KIND_LD},
    '{TBL_BASE, 8'hEF, 8'h22, KIND_LD},   '{TBL_BASE, 8'hC7, 8'h06, KIND_LD},
    '{TBL_BASE, 8'hEF, 8'h0A, KIND_LD},   '{TBL_BASE, 8'hEF, 8'h02, KIND_LD},
    '{TBL_BASE, 8'hF8, 8'h70, KIND_LD},   '{TBL_BASE, 8'hEF, 8'hE2, KIND_LD},
    '{TBL_BASE, 8'hEF, 8'hE0, KIND_LD},   '{TBL_BASE, 8'hEF, 8'hEA, KIND_LD},
    '{TBL_BASE, 8'hFF, 8'hF9, KIND_LD},   '{TBL_BASE, 8'hC7, 8'h46, KIND_LD},
    '{TBL_BASE, 8'hC0, 8'h40, KIND_LD}
  };

endpackage
`default_nettype wire

### hdl/cpu_opcode_class_decoder.sv
// Opcode class decoder top level: table select, pattern match, grouped
// priority encode and final select. Depends on cocd_pkg and cocd_pipe_reg.
// Throughput: one beat per cycle; stalls propagate back through the stages.
// Reset: synchronous, active high; clears all stage valid bits.
`default_nettype none
module cpu_opcode_class_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  opcode_byte,
  input  wire logic        prefix_present,
  input  wire logic [7:0]  prefix_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       instr_kind,
  output logic             unknown_instr
);

  localparam int S1W = 8 + $bits(cocd_pkg::tbl_t);
  localparam int S2W = cocd_pkg::NumRules;
  localparam int S3W = cocd_pkg::NumGroups * $bits(cocd_pkg::grp_t);
  localparam int S4W = 7;

  // stage 1: table select
  cocd_pkg::tbl_t  tbl_sel;
  logic [S1W-1:0]  s1_in, s1_q;
  logic            s1_valid, s1_ready;
  logic [7:0]      s1_op;
  cocd_pkg::tbl_t  s1_tbl;

  always_comb begin
    tbl_sel = cocd_pkg::TBL_BASE;
    if (prefix_present) begin
      if (prefix_byte == cocd_pkg::PREFIX_CB) begin
        tbl_sel = cocd_pkg::TBL_CB;
      end else if (prefix_byte == cocd_pkg::PREFIX_DD ||
                   prefix_byte == cocd_pkg::PREFIX_FD) begin
        tbl_sel = cocd_pkg::TBL_IDX;
      end
    end
  end

  assign s1_in = {opcode_byte, tbl_sel};

  cocd_pipe_reg #(.Width(S1W)) u_s1 (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(s1_in),
    .out_valid(s1_valid), .out_ready(s1_ready), .out_data(s1_q)
  );

  assign s1_op  = s1_q[S1W-1 -: 8];
  assign s1_tbl = cocd_pkg::tbl_t'(s1_q[$bits(cocd_pkg::tbl_t)-1:0]);

  // stage 2: per-pattern hits
  logic [S2W-1:0] hits, s2_q;
  logic           s2_valid, s2_ready;

  always_comb begin
    for (int i = 0; i < cocd_pkg::NumRules; i++) begin
      hits[i] = (cocd_pkg::Rules[i].tbl == s1_tbl) &&
                ((s1_op & cocd_pkg::Rules[i].mask) == cocd_pkg::Rules[i].value);
    end
  end

  cocd_pipe_reg #(.Width(S2W)) u_s2 (
    .clk(clk), .rst(rst),
    .in_valid(s1_valid), .in_ready(s1_ready), .in_data(hits),
    .out_valid(s2_valid), .out_ready(s2_ready), .out_data(s2_q)
  );

  // stage 3: first hit within each group of patterns
  cocd_pkg::grp_t [cocd_pkg::NumGroups-1:0] grp, s3_grp;
  logic [S3W-1:0] s3_q;
  logic           s3_valid, s3_ready;

  always_comb begin
    for (int g = 0; g < cocd_pkg::NumGroups; g++) begin
      grp[g].found = 1'b0;
      grp[g].kind  = cocd_pkg::KIND_BIT;
      // walk backwards so the lowest index is written last and wins
      for (int j = cocd_pkg::GroupSize - 1; j >= 0; j--) begin
        if (g * cocd_pkg::GroupSize + j < cocd_pkg::NumRules) begin
          if (s2_q[g * cocd_pkg::GroupSize + j]) begin
            grp[g].found = 1'b1;
            grp[g].kind  = cocd_pkg::Rules[g * cocd_pkg::GroupSize + j].kind;
          end
        end
      end
    end
  end

  cocd_pipe_reg #(.Width(S3W)) u_s3 (
    .clk(clk), .rst(rst),
    .in_valid(s2_valid), .in_ready(s2_ready), .in_data(grp),
    .out_valid(s3_valid), .out_ready(s3_ready), .out_data(s3_q)
  );

  assign s3_grp = s3_q;

  // stage 4: first group with a hit
  cocd_pkg::kind_t kind_sel;
  logic            any_hit;
  logic [S4W-1:0]  s4_in, s4_q;

  always_comb begin
    kind_sel = cocd_pkg::KIND_BIT;
    any_hit  = 1'b0;
    for (int g = cocd_pkg::NumGroups - 1; g >= 0; g--) begin
      if (s3_grp[g].found) begin
        kind_sel = s3_grp[g].kind;
        any_hit  = 1'b1;
      end
    end
  end

  assign s4_in = {kind_sel, !any_hit};

  cocd_pipe_reg #(.Width(S4W)) u_s4 (
    .clk(clk), .rst(rst),
    .in_valid(s3_valid), .in_ready(s3_ready), .in_data(s4_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(s4_q)
  );

  assign instr_kind    = s4_q[S4W-1:1];
  assign unknown_instr = s4_q[0];

endmodule
`default_nettype wire

### hdl/cocd_pipe_reg.sv
// One valid/ready pipeline register stage with a payload of Width bits.
// No dependencies.
`default_nettype none
module cocd_pipe_reg #(
  parameter int Width = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [Width-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [Width-1:0]      out_data
);

  // stage takes a beat when empty or when its own beat leaves this cycle
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= in_data;
    end
  end

endmodule
`default_nettype wire

### verif/tb_cpu_opcode_class_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for cpu_opcode_class_decoder: random opcode and prefix beats
// with bursty idling on both sides. Results are checked against a local priority decoder.
// Depends on cocd_pkg for the kind, table and prefix codes.
module tb_cpu_opcode_class_decoder;

  typedef struct {
    logic [7:0] op;
    logic       pres;
    logic [7:0] pfx;
    bit         drain;  // hold this beat back until every result is home
    bit         quiet;  // no idling from here on
  } opc_beat_t;

  typedef struct {
    cocd_pkg::kind_t kind;
    logic            unk;
  } opc_class_t;

  localparam int NumRandom = 1100;
  localparam int NumQuiet  = 120;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] opcode_byte = 8'h00;
  logic       prefix_present = 1'b0;
  logic [7:0] prefix_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] instr_kind;
  logic       unknown_instr;

  opc_beat_t  pend_q[$];
  opc_class_t class_q[$];
  int         n_pushed = 0;
  int         n_got = 0;
  int         n_err = 0;
  int         n_cb = 0, n_idx = 0, n_base = 0, n_unk = 0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  bit         calm = 1'b0;
  bit         hold_rx = 1'b0;

  cpu_opcode_class_decoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode_byte    (opcode_byte),
    .prefix_present (prefix_present),
    .prefix_byte    (prefix_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .instr_kind     (instr_kind),
    .unknown_instr  (unknown_instr)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cocd_pkg::tbl_t pick_table(logic pres, logic [7:0] pfx);
    if (pres && pfx == cocd_pkg::PREFIX_CB) return cocd_pkg::TBL_CB;
    if (pres && (pfx == cocd_pkg::PREFIX_DD || pfx == cocd_pkg::PREFIX_FD)) begin
      return cocd_pkg::TBL_IDX;
    end
    return cocd_pkg::TBL_BASE;
  endfunction

  // First matching pattern wins, so case item order is the priority order.
  function automatic opc_class_t classify_opcode(logic [7:0] op, logic pres, logic [7:0] pfx);
    opc_class_t c;
    c.kind = cocd_pkg::KIND_BIT;
    c.unk  = 1'b0;
    case (pick_table(pres, pfx))
      cocd_pkg::TBL_CB: begin
        casez (op)
          8'b01??_????: c.kind = cocd_pkg::KIND_BIT;
          8'b10??_????: c.kind = cocd_pkg::KIND_RES;
          8'b11??_????: c.kind = cocd_pkg::KIND_SET;
          8'b0000_0???: c.kind = cocd_pkg::KIND_RLC;
          8'b0001_0???: c.kind = cocd_pkg::KIND_RL;
          8'b0000_1???: c.kind = cocd_pkg::KIND_RRC;
          8'b0001_1???: c.kind = cocd_pkg::KIND_RR;
          8'b0010_0???: c.kind = cocd_pkg::KIND_SLA;
          8'b0010_1???: c.kind = cocd_pkg::KIND_SRA;
          8'b0011_1???: c.kind = cocd_pkg::KIND_SRL;
          8'b0011_0???: c.kind = cocd_pkg::KIND_SWAP;
          default:      c.unk  = 1'b1;
        endcase
      end
      cocd_pkg::TBL_IDX: begin
        casez (op)
          8'b01??_?110: c.kind = cocd_pkg::KIND_LD;
          8'b0111_0???: c.kind = cocd_pkg::KIND_LD;
          default:      c.unk  = 1'b1;
        endcase
      end
      default: begin
        casez (op)
          8'b0000_0111: c.kind = cocd_pkg::KIND_RLCA;
          8'b0001_0111: c.kind = cocd_pkg::KIND_RLA;
          8'b0001_1000: c.kind = cocd_pkg::KIND_JR;
          8'b001?_?000: c.kind = cocd_pkg::KIND_JR;
          8'b1110_1001: c.kind = cocd_pkg::KIND_JP;
          8'b110?_?01?: c.kind = cocd_pkg::KIND_JP;
          8'b0000_1111: c.kind = cocd_pkg::KIND_RRCA;
          8'b0001_1111: c.kind = cocd_pkg::KIND_RRA;
          8'b00??_1001: c.kind = cocd_pkg::KIND_ADD;
          8'b1000_0110: c.kind = cocd_pkg::KIND_ADD;
          8'b1000_0???: c.kind = cocd_pkg::KIND_ADD;
          8'b1100_0110: c.kind = cocd_pkg::KIND_ADD;
          8'b1110_1000: c.kind = cocd_pkg::KIND_ADD;
          8'b110?_?000: c.kind = cocd_pkg::KIND_RET;
          8'b1100_1001: c.kind = cocd_pkg::KIND_RET;
          8'b1100_1101: c.kind = cocd_pkg::KIND_CALL;
          8'b110?_?100: c.kind = cocd_pkg::KIND_CALL;
          8'b1100_1110: c.kind = cocd_pkg::KIND_ADC;
          8'b1000_1110: c.kind = cocd_pkg::KIND_ADC;
          8'b1000_1???: c.kind = cocd_pkg::KIND_ADC;
          8'b1001_0???: c.kind = cocd_pkg::KIND_SUB;  // whole 0x90..0x97 row, not just 0x96
          8'b1101_0110: c.kind = cocd_pkg::KIND_SUB;
          8'b1101_1110: c.kind = cocd_pkg::KIND_SBC;
          8'b1001_1110: c.kind = cocd_pkg::KIND_SBC;
          8'b1001_1???: c.kind = cocd_pkg::KIND_SBC;
          8'b1110_0110: c.kind = cocd_pkg::KIND_AND;
          8'b1010_0110: c.kind = cocd_pkg::KIND_AND;
          8'b1010_0???: c.kind = cocd_pkg::KIND_AND;
          8'b1111_0110: c.kind = cocd_pkg::KIND_OR;
          8'b1011_0110: c.kind = cocd_pkg::KIND_OR;
          8'b1011_0???: c.kind = cocd_pkg::KIND_OR;
          8'b1110_1110: c.kind = cocd_pkg::KIND_XOR;
          8'b1010_1110: c.kind = cocd_pkg::KIND_XOR;
          8'b1010_1???: c.kind = cocd_pkg::KIND_XOR;
          8'b1111_1000: c.kind = cocd_pkg::KIND_LDHL;
          8'b1111_1110: c.kind = cocd_pkg::KIND_CP;
          8'b1011_1110: c.kind = cocd_pkg::KIND_CP;
          8'b1011_1???: c.kind = cocd_pkg::KIND_CP;
          8'b0011_0100: c.kind = cocd_pkg::KIND_INC;
          8'b00??_?100: c.kind = cocd_pkg::KIND_INC;
          8'b00??_0011: c.kind = cocd_pkg::KIND_INC;
          8'b0011_0101: c.kind = cocd_pkg::KIND_DEC;
          8'b00??_?101: c.kind = cocd_pkg::KIND_DEC;
          8'b00??_1011: c.kind = cocd_pkg::KIND_DEC;
          8'b11??_0101: c.kind = cocd_pkg::KIND_PUSH;
          8'b11??_0001: c.kind = cocd_pkg::KIND_POP;
          8'b0000_1000: c.kind = cocd_pkg::KIND_LD;
          8'b00??_0001: c.kind = cocd_pkg::KIND_LD;
          8'b0011_0110: c.kind = cocd_pkg::KIND_LD;
          8'b001?_1010: c.kind = cocd_pkg::KIND_LD;
          8'b001?_0010: c.kind = cocd_pkg::KIND_LD;
          8'b00??_?110: c.kind = cocd_pkg::KIND_LD;
          8'b000?_1010: c.kind = cocd_pkg::KIND_LD;
          8'b000?_0010: c.kind = cocd_pkg::KIND_LD;
          8'b0111_0???: c.kind = cocd_pkg::KIND_LD;
          8'b111?_0010: c.kind = cocd_pkg::KIND_LD;
          8'b111?_0000: c.kind = cocd_pkg::KIND_LD;
          8'b111?_1010: c.kind = cocd_pkg::KIND_LD;
          8'b1111_1001: c.kind = cocd_pkg::KIND_LD;
          8'b01??_?110: c.kind = cocd_pkg::KIND_LD;
          8'b01??_????: c.kind = cocd_pkg::KIND_LD;
          default:      c.unk  = 1'b1;
        endcase
      end
    endcase
    return c;
  endfunction

  task automatic add_beat(logic [7:0] op, logic pres, logic [7:0] pfx);
    opc_beat_t b;
    b.op    = op;
    b.pres  = pres;
    b.pfx   = pfx;
    b.drain = 1'b0;
    b.quiet = 1'b0;
    pend_q.push_back(b);
  endtask

  // Sender: the expected class is queued as the beat is first offered; valid then holds
  // until the beat is taken, so queue order matches acceptance order.
  always @(posedge clk) begin : drv
    opc_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap != 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0 && !(pend_q[0].drain && n_got != n_pushed)) begin
        nb = pend_q.pop_front();
        opcode_byte    <= nb.op;
        prefix_present <= nb.pres;
        prefix_byte    <= nb.pfx;
        in_valid       <= 1'b1;
        class_q.push_back(classify_opcode(nb.op, nb.pres, nb.pfx));
        n_pushed++;
        case (pick_table(nb.pres, nb.pfx))
          cocd_pkg::TBL_CB:  n_cb++;
          cocd_pkg::TBL_IDX: n_idx++;
          default:           n_base++;
        endcase
        if (nb.quiet) calm <= 1'b1;
        if (!nb.quiet && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin : mon
    opc_class_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (class_q.size() == 0) begin
          n_err++;
          $error("result beat with nothing expected: instr_kind %0d unknown_instr %0b",
                 instr_kind, unknown_instr);
        end else begin
          e = class_q.pop_front();
          n_got <= n_got + 1;
          if (e.unk) n_unk++;
          if (instr_kind !== e.kind) begin
            n_err++;
            $error("instr_kind: expected %0d (%s), got %0d", e.kind, e.kind.name(),
                   instr_kind);
          end
          if (unknown_instr !== e.unk) begin
            n_err++;
            $error("unknown_instr: expected %0b, got %0b", e.unk, unknown_instr);
          end
        end
      end
      if (hold_rx) begin
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        rx_gap = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long sink stall once traffic is flowing, so the pipe fills and in_ready drops.
  initial begin : sink_hold
    do @(negedge clk); while (n_got < 150);
    hold_rx = 1'b1;
    repeat (60) @(negedge clk);
    hold_rx = 1'b0;
  end

  initial begin : limit
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stim
    logic [7:0] op;
    logic [7:0] pfx;
    logic       pres;
    int         drain_at;

    // CB table: corners and one opcode from some of the groups
    add_beat(8'h00, 1'b1, cocd_pkg::PREFIX_CB);
    add_beat(8'hFF, 1'b1, cocd_pkg::PREFIX_CB);
    add_beat(8'h47, 1'b1, cocd_pkg::PREFIX_CB);
    add_beat(8'h87, 1'b1, cocd_pkg::PREFIX_CB);
    add_beat(8'h37, 1'b1, cocd_pkg::PREFIX_CB);
    add_beat(8'h3F, 1'b1, cocd_pkg::PREFIX_CB);
    add_beat(8'h28, 1'b1, cocd_pkg::PREFIX_CB);
    // index prefixes know only ld forms
    add_beat(8'h46, 1'b1, cocd_pkg::PREFIX_DD);
    add_beat(8'h75, 1'b1, cocd_pkg::PREFIX_DD);
    add_beat(8'h00, 1'b1, cocd_pkg::PREFIX_DD);
    add_beat(8'hFF, 1'b1, cocd_pkg::PREFIX_FD);
    add_beat(8'h7E, 1'b1, cocd_pkg::PREFIX_FD);
    add_beat(8'h40, 1'b1, cocd_pkg::PREFIX_FD);
    // base table, including opcodes nothing matches and opcodes from the sub row
    add_beat(8'h00, 1'b0, 8'h00);
    add_beat(8'hFF, 1'b0, 8'hFF);
    add_beat(8'h90, 1'b0, 8'h00);
    add_beat(8'h96, 1'b0, 8'h00);
    add_beat(8'h97, 1'b0, 8'h00);
    add_beat(8'h76, 1'b0, 8'h00);
    add_beat(8'hF8, 1'b0, 8'h00);
    add_beat(8'hE9, 1'b0, 8'h00);
    // prefix byte ignored when absent; unrecognised prefix falls back to base
    add_beat(8'h40, 1'b0, cocd_pkg::PREFIX_CB);
    add_beat(8'h07, 1'b1, 8'h12);
    add_beat(8'hC9, 1'b1, 8'hCA);

    drain_at = $urandom_range(NumRandom / 3, 2 * NumRandom / 3);
    for (int i = 0; i < NumRandom; i++) begin
      op = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: begin
          pres = 1'b0;
          pfx  = 8'($urandom_range(0, 255));
        end
        1: begin
          pres = 1'b1;
          pfx  = cocd_pkg::PREFIX_CB;
        end
        2: begin
          pres = 1'b1;
          pfx  = $urandom_range(0, 1) ? cocd_pkg::PREFIX_DD : cocd_pkg::PREFIX_FD;
        end
        default: begin
          pres = 1'b1;
          pfx  = 8'($urandom_range(0, 255));
        end
      endcase
      add_beat(op, pres, pfx);
      if (i == drain_at) pend_q[pend_q.size() - 1].drain = 1'b1;
      if (i >= NumRandom - NumQuiet) pend_q[pend_q.size() - 1].quiet = 1'b1;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (pend_q.size() != 0 || in_valid);
    do @(negedge clk); while (n_got != n_pushed);
    repeat (12) @(negedge clk);

    if (class_q.size() != 0) begin
      n_err += class_q.size();
      $error("%0d expected results never arrived", class_q.size());
    end
    $display("checked %0d class results from %0d opcode beats (cb %0d, dd/fd %0d, base %0d)",
             n_got, n_pushed, n_cb, n_idx, n_base);
    $display("%0d of them unknown; one long sink stall and one sender drain pause", n_unk);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
